// ===== rtl/burst_round_robin_four_queues_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-queue round-robin scheduler
// Shared forms of clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BURST_ROUND_ROBIN_FOUR_QUEUES_MACROS_SVH
`define BURST_ROUND_ROBIN_FOUR_QUEUES_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRR4Q_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BRR4Q_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/brr4q_pkg.sv =====
// ----------------------------------------------------------------------------
// brr4q_pkg
// Types and constants of the four-queue round-robin scheduler.
// ----------------------------------------------------------------------------
package brr4q_pkg;

   localparam int QUEUE_DEPTH = 1024;
   localparam int NUM_DIRS    = 4;
   localparam int DIR_W       = 2;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = DIR_W + IDX_W;
   localparam int TAG_W       = 32;
   localparam int DUR_W       = 16;
   localparam int ENTRY_W     = TAG_W + DUR_W;
   localparam int BURST_W     = 4;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   typedef logic [DIR_W-1:0]   dir_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [BURST_W-1:0] burst_type;

   typedef enum logic [1:0] {
      ST_GRANTED  = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_ENQUEUED = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_GRANT   = 1'b1;

   // Register select bit of the CSR address (word index).
   localparam logic REG_START = 1'b0;
   localparam logic REG_BURST = 1'b1;

endpackage

// ===== rtl/burst_round_robin_four_queues.sv =====
// ----------------------------------------------------------------------------
// burst_round_robin_four_queues
// Four direction FIFOs in one queue memory, served round robin with a
// per-turn burst limit.
// ----------------------------------------------------------------------------
// The result strobe rises in the cycle after start is taken.
// No new transaction is taken while a result is pending; busy covers the cycle in which
//   the queue memory read completes and the result is presented.
// Reset clears pointers, fill counts, turn state and configuration registers
//   (start direction 0, burst one); the queue memory is not cleared.
// Results cannot be stalled; each strobe lasts exactly one cycle.
module burst_round_robin_four_queues
   import brr4q_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [DIR_W-1:0]    req_direction,
   input  logic [TAG_W-1:0]    req_item_tag,
   input  logic [DUR_W-1:0]    req_duration,
   // result channel
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [DIR_W-1:0]    rsp_granted_direction,
   output logic [TAG_W-1:0]    rsp_granted_tag,
   output logic [DUR_W-1:0]    rsp_granted_duration,
   output logic                rsp_first_of_turn,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   // Queue memory: one row per direction, QUEUE_DEPTH entries each.
   logic [ENTRY_W-1:0] mem [NUM_DIRS * (1 << IDX_W)];

   // Registers
   dir_type            start_dir_ff;
   burst_type          burst_ff;
   dir_type            cur_dir_ff,  cur_dir_in;
   burst_type          served_ff,   served_in;
   idx_type            head_ff  [NUM_DIRS];
   idx_type            head_in  [NUM_DIRS];
   cnt_type            count_ff [NUM_DIRS];
   cnt_type            count_in [NUM_DIRS];
   logic               rsp_valid_ff;
   status_type         rsp_status_ff, rsp_status_in;
   dir_type            rsp_dir_ff,    rsp_dir_in;
   logic               rsp_first_ff,  rsp_first_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               accept;
   logic               cfg_write;
   logic               enq_ok;
   logic               grant_hit;
   logic               any_waiting;
   dir_type            sel_dir;
   dir_type            sel_off;
   burst_type          burst_eff;
   burst_type          served_sum;
   logic [CNT_W:0]     pos_sum;
   idx_type            wr_idx;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               queues_empty;
   logic               rsp_is_empty;
   logic               rsp_not_granted;
   logic               payload_clear;

   // A transaction is taken only while no result is pending, so a write
   // to the queue memory never meets a read in the same cycle.
   assign accept    = start && !busy;
   assign busy      = rsp_valid_ff;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_BURST) ? CSR_DW'(burst_ff) : CSR_DW'(start_dir_ff);

   assign burst_eff = (burst_ff == '0) ? burst_type'(1) : burst_ff;

   // Search the four queues starting at the current direction; lowest
   // rotation offset with a waiting item wins.
   always_comb begin
      any_waiting = 1'b0;
      sel_off     = '0;
      for (int o = NUM_DIRS - 1; o >= 0; o--) begin
         if (count_ff[cur_dir_ff + dir_type'(o)] != '0) begin
            any_waiting = 1'b1;
            sel_off     = dir_type'(o);
         end
      end
   end

   assign sel_dir    = cur_dir_ff + sel_off;
   // Skipping an empty queue closes that turn, so the count restarts.
   assign served_sum = ((sel_off == '0) ? served_ff : '0) + burst_type'(1);
   assign grant_hit  = accept && (req_action == ACT_GRANT) && any_waiting;

   // Tail position of the enqueue direction, wrapped into the ring.
   always_comb begin
      pos_sum = (CNT_W+1)'(head_ff[req_direction]) + (CNT_W+1)'(count_ff[req_direction]);
      if (pos_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         pos_sum = pos_sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
   end

   assign wr_idx  = pos_sum[IDX_W-1:0];
   assign enq_ok  = accept && (req_action == ACT_ENQUEUE)
                    && (count_ff[req_direction] < CNT_W'(QUEUE_DEPTH));
   assign wr_addr = {req_direction, wr_idx};
   assign rd_addr = {sel_dir, head_ff[sel_dir]};

   // Next state of pointers, counts and turn, plus the result fields.
   always_comb begin
      cur_dir_in    = cur_dir_ff;
      served_in     = served_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_first_in  = rsp_first_ff;
      for (int d = 0; d < NUM_DIRS; d++) begin
         head_in[d]  = head_ff[d];
         count_in[d] = count_ff[d];
      end

      if (cfg_write && (paddr[2] == REG_START)) begin
         cur_dir_in = pwdata[DIR_W-1:0];
         served_in  = '0;
      end

      if (accept) begin
         rsp_dir_in   = '0;
         rsp_first_in = 1'b0;
         if (req_action == ACT_ENQUEUE) begin
            if (enq_ok) begin
               count_in[req_direction] = count_ff[req_direction] + cnt_type'(1);
               rsp_status_in           = ST_ENQUEUED;
            end else begin
               rsp_status_in = ST_DROPPED;
            end
         end else if (!any_waiting) begin
            // Close a turn that already served items.
            if (served_ff != '0) begin
               cur_dir_in = cur_dir_ff + dir_type'(1);
               served_in  = '0;
            end
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in    = ST_GRANTED;
            rsp_dir_in       = sel_dir;
            rsp_first_in     = (sel_off != '0) || (served_ff == '0);
            head_in[sel_dir] = (head_ff[sel_dir] == idx_type'(QUEUE_DEPTH - 1))
                               ? '0 : head_ff[sel_dir] + idx_type'(1);
            count_in[sel_dir] = count_ff[sel_dir] - cnt_type'(1);
            // Advance to the next direction once the burst is used up.
            if (served_sum >= burst_eff) begin
               cur_dir_in = sel_dir + dir_type'(1);
               served_in  = '0;
            end else begin
               cur_dir_in = sel_dir;
               served_in  = served_sum;
            end
         end
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_dir_ff <= '0;
         burst_ff     <= burst_type'(1);
         cur_dir_ff   <= '0;
         served_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < NUM_DIRS; d++) begin
            head_ff[d]  <= '0;
            count_ff[d] <= '0;
         end
      end else begin
         if (cfg_write && (paddr[2] == REG_START)) begin
            start_dir_ff <= pwdata[DIR_W-1:0];
         end
         if (cfg_write && (paddr[2] == REG_BURST)) begin
            burst_ff <= pwdata[BURST_W-1:0];
         end
         cur_dir_ff   <= cur_dir_in;
         served_ff    <= served_in;
         rsp_valid_ff <= accept;
         for (int d = 0; d < NUM_DIRS; d++) begin
            head_ff[d]  <= head_in[d];
            count_ff[d] <= count_in[d];
         end
      end
   end

   // Result fields: payload, no reset.
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_first_ff  <= rsp_first_in;
   end

   // Queue memory: write on enqueue, registered read of the granted head.
   always_ff @(posedge clock) begin
      if (enq_ok) begin
         mem[wr_addr] <= {req_item_tag, req_duration};
      end
      if (grant_hit) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Drive the result ports; payload stays zero unless granted.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_granted_direction = rsp_dir_ff;
   assign rsp_first_of_turn     = rsp_first_ff;
   assign rsp_granted_tag       = (rsp_status_ff == ST_GRANTED)
                                  ? rd_data_ff[ENTRY_W-1:DUR_W] : '0;
   assign rsp_granted_duration  = (rsp_status_ff == ST_GRANTED)
                                  ? rd_data_ff[DUR_W-1:0] : '0;

   // Terms of the result checks.
   assign queues_empty    = (count_ff[0] == '0) && (count_ff[1] == '0)
                            && (count_ff[2] == '0) && (count_ff[3] == '0);
   assign rsp_is_empty    = rsp_valid && (rsp_status_ff == ST_EMPTY);
   assign rsp_not_granted = rsp_valid && (rsp_status_ff != ST_GRANTED);
   assign payload_clear   = (rsp_granted_direction == '0) && !rsp_first_of_turn;

`include "burst_round_robin_four_queues_macros.svh"

   `BRR4Q_ASSERT_NEXT(a_result_follows, clock, reset, accept, rsp_valid)
   `BRR4Q_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `BRR4Q_ASSERT_SAME(a_empty_means_empty, clock, reset, rsp_is_empty, queues_empty)
   `BRR4Q_ASSERT_SAME(a_no_stale_payload, clock, reset, rsp_not_granted, payload_clear)

endmodule
